// ----- rtl/bitpacked_transitive_closure_macros.svh -----
// ----------------------------------------------------------------------------
// bitpacked_transitive_closure_macros
// assertion helpers for the closure block, removable with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef BITPACKED_TRANSITIVE_CLOSURE_MACROS_SVH
`define BITPACKED_TRANSITIVE_CLOSURE_MACROS_SVH

`ifndef ASSERT_OFF

`define BTC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define BTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BTC_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define BTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/btc_pkg.sv -----
// ----------------------------------------------------------------------------
// btc_pkg
// shared widths and the reset value of the bit-packed transitive closure block
// ----------------------------------------------------------------------------
`default_nettype none

package btc_pkg;

   localparam int unsigned MAX_VERTICES_DEFAULT = 64;

   localparam int unsigned VERTEX_W = 6;
   localparam int unsigned ROW_W    = 64;
   localparam int unsigned COUNT_W  = 13;
   localparam int unsigned SCC_W    = 7;
   localparam int unsigned NV_W     = 7;

   localparam logic [NV_W-1:0] NUM_VERTICES_RESET = 7'd64;

endpackage

`default_nettype wire

// ----- rtl/btc_channels.sv -----
// ----------------------------------------------------------------------------
// btc_channels
// valid/ready channels of the closure block: edge items, row items, csr write
// ----------------------------------------------------------------------------
`default_nettype none

interface btc_req_if;
   import btc_pkg::*;

   logic                valid;
   logic                ready;
   logic                edge_valid;
   logic [VERTEX_W-1:0] edge_src;
   logic [VERTEX_W-1:0] edge_dst;
   logic                last_edge;

   modport source (output valid, edge_valid, edge_src, edge_dst, last_edge, input ready);
   modport sink   (input valid, edge_valid, edge_src, edge_dst, last_edge, output ready);
endinterface

interface btc_rsp_if;
   import btc_pkg::*;

   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] row_index;
   logic [ROW_W-1:0]    row_bits;
   logic [COUNT_W-1:0]  closure_entries;
   logic [SCC_W-1:0]    scc_count;
   logic                last_row;

   modport source (output valid, row_index, row_bits, closure_entries, scc_count, last_row,
                   input ready);
   modport sink   (input valid, row_index, row_bits, closure_entries, scc_count, last_row,
                   output ready);
endinterface

interface btc_csr_if;
   import btc_pkg::*;

   logic            valid;
   logic            ready;
   logic [NV_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bitpacked_transitive_closure.sv -----
// ----------------------------------------------------------------------------
// bitpacked_transitive_closure
// edge loader, Warshall closure and component count over a row memory
//
//   channel    dir   payload                                          handshake
//   req_chan   in    edge_valid, edge_src, edge_dst, last_edge        valid/ready
//   rsp_chan   out   row_index, row_bits, closure_entries, scc_count,  valid/ready
//                    last_row
//   csr_chan   in    num_vertices                                     valid/ready
//
// edges load at one item per cycle through a read-modify-write of the row memory
// after the last item, closure and then component scan run on the row memory,
// then the ST_FLUSH and ST_SETTLE states; a row is read for output only once
// the previous one is in the output register and that register is free or taken
// reset and the end of a run clear the matrix at once through per-row valid bits
// a stalled result holds in the output register; csr writes are always taken
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitpacked_transitive_closure_macros.svh"

module bitpacked_transitive_closure #(
   parameter int unsigned MAX_VERTICES = btc_pkg::MAX_VERTICES_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   btc_req_if.sink     req_chan,
   btc_rsp_if.source   rsp_chan,
   btc_csr_if.sink     csr_chan
);
   import btc_pkg::*;

   localparam int unsigned AW = $clog2(MAX_VERTICES);
   localparam logic [NV_W-1:0] MaxN = NV_W'(MAX_VERTICES);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PIVOT,
      ST_ROWS,
      ST_FLUSH,
      ST_SETTLE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_PIVOT,
      OP_ROW,
      OP_SCAN_PIVOT,
      OP_SCAN_ROW,
      OP_EMIT
   } op_type;

   function automatic logic [MAX_VERTICES-1:0] bit_of(input logic [AW-1:0] idx);
      logic [MAX_VERTICES-1:0] one;
      one = {{(MAX_VERTICES-1){1'b0}}, 1'b1};
      return one << idx;
   endfunction

   // configuration and run control
   logic [NV_W-1:0] nv_ff;
   logic [NV_W-1:0] n_act;
   logic [NV_W-1:0] n_last;
   state_type       state_ff, state_in;
   logic            scan_ff, scan_in;
   logic [AW-1:0]   i_ff, i_in;
   logic [AW-1:0]   k_ff, k_in;
   logic            i_last, k_last;

   // issue side
   logic            req_fire;
   logic            edge_ok;
   logic            iss_en;
   op_type          iss_op;
   logic [AW-1:0]   rd_addr;
   logic            iss_end;
   logic            iss_last;
   logic            clear_rows;
   logic            start_run;
   logic            emit_busy;

   // data-return stage
   logic            p_valid_ff;
   op_type          p_op_ff;
   logic [AW-1:0]   p_addr_ff;
   logic [AW-1:0]   p_k_ff;
   logic [AW-1:0]   p_dst_ff;
   logic            p_end_ff;
   logic            p_last_ff;

   // row memory
   logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
   logic [MAX_VERTICES-1:0] rd_data_ff;
   logic                    rd_valid_ff;
   logic [MAX_VERTICES-1:0] row_valid_ff;
   logic                    byp_ff;
   logic [MAX_VERTICES-1:0] byp_data_ff;
   logic [MAX_VERTICES-1:0] col_mask;
   logic [MAX_VERTICES-1:0] raw;
   logic [MAX_VERTICES-1:0] eff;
   logic                    wr_en;
   logic [MAX_VERTICES-1:0] wr_data;

   // closure and statistics
   logic [MAX_VERTICES-1:0] rowk_ff;
   logic [MAX_VERTICES-1:0] col_ff;
   logic [MAX_VERTICES-1:0] grouped_ff;
   logic [COUNT_W-1:0]      entry_total_ff;
   logic [SCC_W-1:0]        scc_ff;
   logic                    eval_ff;
   logic [AW-1:0]           eval_k_ff;
   logic [NV_W-1:0]         row_pop;

   // result register
   logic                rsp_valid_ff;
   logic [VERTEX_W-1:0] rsp_index_ff;
   logic [ROW_W-1:0]    rsp_bits_ff;
   logic [COUNT_W-1:0]  rsp_entries_ff;
   logic [SCC_W-1:0]    rsp_scc_ff;
   logic                rsp_last_ff;

   assign n_act  = (nv_ff > MaxN) ? MaxN : nv_ff;
   assign n_last = n_act - NV_W'(1);
   assign i_last = (NV_W'(i_ff) == n_last);
   assign k_last = (NV_W'(k_ff) == n_last);

   assign req_chan.ready = (state_ff == ST_LOAD);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign edge_ok        = req_chan.edge_valid
                           && (NV_W'(req_chan.edge_src) < n_act)
                           && (NV_W'(req_chan.edge_dst) < n_act);
   assign emit_busy      = p_valid_ff && (p_op_ff == OP_EMIT);

   assign csr_chan.ready = 1'b1;

   always_comb begin
      state_in   = state_ff;
      scan_in    = scan_ff;
      i_in       = i_ff;
      k_in       = k_ff;
      iss_en     = 1'b0;
      iss_op     = OP_LOAD;
      rd_addr    = '0;
      iss_end    = 1'b0;
      iss_last   = 1'b0;
      clear_rows = 1'b0;
      start_run  = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (edge_ok) begin
                  iss_en  = 1'b1;
                  iss_op  = OP_LOAD;
                  rd_addr = req_chan.edge_src[AW-1:0];
               end
               if (req_chan.last_edge) begin
                  if (n_act == '0) begin
                     clear_rows = 1'b1;
                  end else begin
                     start_run = 1'b1;
                     scan_in   = 1'b0;
                     k_in      = '0;
                     state_in  = ST_PIVOT;
                  end
               end
            end
         end
         ST_PIVOT: begin
            iss_en   = 1'b1;
            iss_op   = scan_ff ? OP_SCAN_PIVOT : OP_PIVOT;
            rd_addr  = k_ff;
            i_in     = '0;
            state_in = ST_ROWS;
         end
         ST_ROWS: begin
            iss_en  = 1'b1;
            iss_op  = scan_ff ? OP_SCAN_ROW : OP_ROW;
            rd_addr = i_ff;
            i_in    = i_ff + AW'(1);
            if (i_last) begin
               iss_end = 1'b1;
               i_in    = '0;
               if (k_last) begin
                  k_in = '0;
                  if (!scan_ff) begin
                     scan_in  = 1'b1;
                     state_in = ST_PIVOT;
                  end else begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = ST_PIVOT;
               end
            end
         end
         ST_FLUSH: begin
            state_in = ST_SETTLE;
         end
         ST_SETTLE: begin
            i_in     = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!emit_busy && (!rsp_valid_ff || rsp_chan.ready)) begin
               iss_en   = 1'b1;
               iss_op   = OP_EMIT;
               rd_addr  = i_ff;
               iss_last = i_last;
               i_in     = i_ff + AW'(1);
               if (i_last) begin
                  i_in       = '0;
                  clear_rows = 1'b1;
                  scan_in    = 1'b0;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // read data with forwarding of the write that shared the read cycle
   always_comb begin
      for (int j = 0; j < MAX_VERTICES; j++) begin
         col_mask[j] = (NV_W'(j) < n_act);
      end
      if (byp_ff) begin
         raw = byp_data_ff;
      end else if (rd_valid_ff) begin
         raw = rd_data_ff;
      end else begin
         raw = '0;
      end
      eff     = (raw & col_mask) | bit_of(p_addr_ff);
      row_pop = NV_W'($countones(eff));
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_data = eff;
      if (p_valid_ff) begin
         case (p_op_ff)
            OP_LOAD: begin
               wr_en   = 1'b1;
               wr_data = raw | bit_of(p_dst_ff);
            end
            OP_ROW: begin
               if (eff[p_k_ff]) begin
                  wr_en   = 1'b1;
                  wr_data = eff | rowk_ff;
               end
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[p_addr_ff] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nv_ff          <= NUM_VERTICES_RESET;
         state_ff       <= ST_LOAD;
         scan_ff        <= 1'b0;
         i_ff           <= '0;
         k_ff           <= '0;
         p_valid_ff     <= 1'b0;
         row_valid_ff   <= '0;
         byp_ff         <= 1'b0;
         eval_ff        <= 1'b0;
         grouped_ff     <= '0;
         entry_total_ff <= '0;
         scc_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            nv_ff <= csr_chan.data;
         end
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         i_ff       <= i_in;
         k_ff       <= k_in;
         p_valid_ff <= iss_en;
         byp_ff     <= wr_en && (p_addr_ff == rd_addr);
         eval_ff    <= p_valid_ff && (p_op_ff == OP_SCAN_ROW) && p_end_ff;

         if (clear_rows) begin
            row_valid_ff <= '0;
         end else if (wr_en) begin
            row_valid_ff[p_addr_ff] <= 1'b1;
         end

         if (start_run) begin
            grouped_ff     <= '0;
            entry_total_ff <= '0;
            scc_ff         <= '0;
         end else begin
            if (p_valid_ff && (p_op_ff == OP_SCAN_PIVOT)) begin
               entry_total_ff <= entry_total_ff + COUNT_W'(row_pop);
            end
            if (eval_ff && !grouped_ff[eval_k_ff]) begin
               scc_ff     <= scc_ff + SCC_W'(1);
               grouped_ff <= grouped_ff | (rowk_ff & col_ff);
            end
         end

         if (emit_busy) begin
            rsp_valid_ff   <= 1'b1;
            rsp_index_ff   <= VERTEX_W'(p_addr_ff);
            rsp_bits_ff    <= ROW_W'(eff);
            rsp_entries_ff <= p_last_ff ? entry_total_ff : '0;
            rsp_scc_ff     <= p_last_ff ? scc_ff : '0;
            rsp_last_ff    <= p_last_ff;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= row_valid_ff[rd_addr];
      byp_data_ff <= wr_data;
      p_op_ff     <= iss_op;
      p_addr_ff   <= rd_addr;
      p_k_ff      <= k_ff;
      p_dst_ff    <= req_chan.edge_dst[AW-1:0];
      p_end_ff    <= iss_end;
      p_last_ff   <= iss_last;
      eval_k_ff   <= p_k_ff;
      if (p_valid_ff && (p_op_ff inside {OP_PIVOT, OP_SCAN_PIVOT})) begin
         rowk_ff <= eff;
      end
      if (p_valid_ff && (p_op_ff == OP_SCAN_ROW)) begin
         col_ff[p_addr_ff] <= eff[p_k_ff];
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.row_index       = rsp_index_ff;
   assign rsp_chan.row_bits        = rsp_bits_ff;
   assign rsp_chan.closure_entries = rsp_entries_ff;
   assign rsp_chan.scc_count       = rsp_scc_ff;
   assign rsp_chan.last_row        = rsp_last_ff;

   // a returning row never lands on an item still waiting at the output
   `BTC_ASSERT_IMPLY(a_emit_slot_free, clock, reset, emit_busy, !rsp_valid_ff || rsp_chan.ready, "emit row overwrites pending item")

   // the run-end clear never races a row write
   `BTC_ASSERT_IMPLY(a_clear_no_write, clock, reset, clear_rows, !wr_en, "matrix clear coincides with row write")

   // statistics show only on the final row
   `BTC_ASSERT_IMPLY(a_stats_last_only, clock, reset, rsp_valid_ff && !rsp_last_ff, (rsp_entries_ff == '0) && (rsp_scc_ff == '0), "statistics on a non-final row")

   // after a clear the next read sees an empty matrix
   `BTC_ASSERT_NEXT(a_cleared_rows, clock, reset, clear_rows, row_valid_ff == '0, "rows still valid after clear")

endmodule

`default_nettype wire
